>>> src/lpe_pkg.sv
// Shared types and constants for the Legendre polynomial evaluator.
// Holds command/status structs, operation codes and the square-root scale table.
// No dependencies.
`default_nettype none

package lpe_pkg;

	// Fixed-point anchors
	localparam logic signed [63:0] ONE_Q52 = 64'sd1 <<< 52;
	localparam logic signed [63:0] ONE_Q40 = 64'sd1 <<< 40;
	localparam logic signed [31:0] ONE_Q28 = 32'sd268435456;

	// Configuration register indexes
	localparam logic [1:0] CFG_POLY_DEGREE = 2'd0;
	localparam logic [1:0] CFG_NORM_MODE   = 2'd1;

	// Normalization modes (code 3 behaves like NORM_SQRT_TWO)
	localparam logic [1:0] NORM_SQRT_ORDER = 2'd0;
	localparam logic [1:0] NORM_NONE       = 2'd1;
	localparam logic [1:0] NORM_SQRT_TWO   = 2'd2;

	// Operations of the shared multiplier
	typedef enum logic [1:0] {
		MOP_XP,
		MOP_SLOPE,
		MOP_VAL,
		MOP_SLP
	} mul_op_t;

	// Rounding shift applied to a product
	typedef enum logic [1:0] {
		SH_28,
		SH_47,
		SH_48,
		SH_60
	} shift_t;

	// Controller to datapath commands (one-cycle pulses)
	typedef struct packed {
		logic    load;
		logic    recip_go;
		logic    mul_go;
		mul_op_t mul_op;
		logic    slope_fix;
		logic    emit;
		logic    next;
	} lpe_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic need_recip;
		logic recip_done;
		logic mul_done;
		logic k_ge1;
		logic slope_by_mul;
		logic k_last;
		logic step_done;
	} lpe_stat_t;

	typedef logic [31:0][43:0] sqrt_tab_t;

	// Truncated sqrt(n) in Q40, digit-by-digit
	function automatic logic [43:0] sqrt_q40(input logic [7:0] n);
		logic [63:0] root;
		logic [63:0] rem;
		logic [63:0] pair;
		logic [63:0] trial;
		root = '0;
		rem  = '0;
		for (int i = 0; i < 44; i++) begin
			pair  = (i < 4) ? 64'((n >> (2 * (3 - i))) & 8'd3) : 64'd0;
			rem   = (rem << 2) | pair;
			trial = (root << 2) | 64'd1;
			if (rem >= trial) begin
				rem  = rem - trial;
				root = (root << 1) | 64'd1;
			end else begin
				root = root << 1;
			end
		end
		return root[43:0];
	endfunction

	function automatic sqrt_tab_t build_sqrt_tab();
		sqrt_tab_t tab;
		for (int n = 0; n < 32; n++) begin
			tab[n] = sqrt_q40(8'(n));
		end
		return tab;
	endfunction

	localparam sqrt_tab_t SQRT_TAB = build_sqrt_tab();

endpackage

`default_nettype wire

>>> src/legendre_poly_eval.sv
// Legendre polynomial evaluator, top level: configuration registers, controller
// and datapath. Uses lpe_pkg, lpe_ctrl and lpe_datapath.
//
// A point is taken when start is high and busy is low. The point, the degree
// and the mode are captured at that edge. The block then emits D+1 results
// (k = 0..D, D = min(poly_degree, MAX_DEGREE)). Each result is shown for one
// cycle with result_valid, and the receiver cannot stall it. Degree 0 takes two
// products; degree 1, and any higher degree of a point at exactly +-1, take
// three. Any other degree of two or more takes four products on the shared
// multiplier (each from four 32x32 partial products plus hand-off), a recurrence
// step with its divide, and sequencing. The last degree skips the recurrence
// step. For |x| < 1 and D >= 2, the 1/(1 - x^2) reciprocal is computed first,
// at one quotient bit a cycle. Busy drops after the last strobe is issued, and
// the next point can then be taken. Configuration writes are always accepted.
`default_nettype none

module legendre_poly_eval import lpe_pkg::*; #(
	parameter int MAX_DEGREE = 15
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] x_point,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [3:0]         cfg_data,
	output logic               result_valid,
	output logic [3:0]         order_index,
	output logic signed [47:0] poly_value,
	output logic signed [47:0] poly_slope,
	output logic               last_of_run
);

	logic [3:0]         degree_q;
	logic [1:0]         mode_q;
	logic [3:0]         deg_eff;
	logic signed [31:0] x_hold_q;
	logic [3:0]         deg_hold_q;
	logic [1:0]         mode_hold_q;
	lpe_cmd_t           cmd;
	lpe_stat_t          stat;

	// Configuration registers
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			degree_q <= '0;
			mode_q   <= NORM_SQRT_ORDER;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_POLY_DEGREE) begin
				degree_q <= cfg_data;
			end else if (cfg_index == CFG_NORM_MODE) begin
				mode_q <= cfg_data[1:0];
			end
		end
	end

	assign deg_eff = (int'(degree_q) > MAX_DEGREE) ? 4'(MAX_DEGREE) : degree_q;

	// Transaction capture at the accepting edge
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_hold_q    <= '0;
			deg_hold_q  <= '0;
			mode_hold_q <= NORM_SQRT_ORDER;
		end else if (start && !busy) begin
			x_hold_q    <= x_point;
			deg_hold_q  <= deg_eff;
			mode_hold_q <= mode_q;
		end
	end

	lpe_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.stat   (stat)
	);

	lpe_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.x_point      (x_hold_q),
		.deg_in       (deg_hold_q),
		.mode_in      (mode_hold_q),
		.result_valid (result_valid),
		.order_index  (order_index),
		.poly_value   (poly_value),
		.poly_slope   (poly_slope),
		.last_of_run  (last_of_run)
	);

	// An accepted point keeps the block busy
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy not raised after accepted point");

	// A result strobe is never directly followed by another
	a_strobe_gap: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("back-to-back result strobes");

	// A result that is not the last leaves the run in progress
	a_run_open: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !last_of_run) |=> busy)
		else $error("run ended before last result");

endmodule

`default_nettype wire

>>> src/lpe_mul.sv
// Shared sequential multiplier: |a|*|b| from four 32x32 partial products,
// rounded half away from zero, shifted and saturated to 64 bits. Uses lpe_pkg.
`default_nettype none

module lpe_mul import lpe_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               go,
	input  logic signed [63:0] a,
	input  logic signed [63:0] b,
	input  shift_t             sh,
	output logic               done,
	output logic signed [63:0] prod
);

	logic [63:0]  ua_q;
	logic [63:0]  ub_q;
	logic         neg_q;
	shift_t       sh_q;
	logic [2:0]   cnt_q;
	logic [63:0]  pp_q;
	logic [127:0] acc_q;
	logic         done_q;
	logic signed [63:0] prod_q;

	logic [31:0]  pa;
	logic [31:0]  pb;
	logic [127:0] sum;
	logic [127:0] shifted;
	logic [63:0]  mag;

	// Partial product operand halves per step
	assign pa = (cnt_q >= 3'd3) ? ua_q[63:32] : ua_q[31:0];
	assign pb = cnt_q[0] ? ub_q[31:0] : ub_q[63:32];

	// Round, shift, saturate
	always_comb begin
		case (sh_q)
			SH_28: begin
				sum     = acc_q + (128'd1 << 27);
				shifted = sum >> 28;
			end
			SH_47: begin
				sum     = acc_q + (128'd1 << 46);
				shifted = sum >> 47;
			end
			SH_48: begin
				sum     = acc_q + (128'd1 << 47);
				shifted = sum >> 48;
			end
			default: begin
				sum     = acc_q + (128'd1 << 59);
				shifted = sum >> 60;
			end
		endcase
		mag = (|shifted[127:63]) ? {1'b0, {63{1'b1}}} : shifted[63:0];
	end

	// Step sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (cnt_q)
				3'd0: if (go) begin
					cnt_q <= 3'd1;
				end
				3'd6: begin
					done_q <= 1'b1;
					cnt_q  <= 3'd0;
				end
				default: cnt_q <= cnt_q + 3'd1;
			endcase
		end
	end

	// Operand capture, partial products and accumulation
	always_ff @(posedge clk) begin
		if (cnt_q == 3'd0 && go) begin
			ua_q  <= a[63] ? 64'(-a) : a;
			ub_q  <= b[63] ? 64'(-b) : b;
			neg_q <= a[63] ^ b[63];
			sh_q  <= sh;
		end
		if (cnt_q >= 3'd1 && cnt_q <= 3'd4) begin
			pp_q <= 64'(pa * pb);
		end
		case (cnt_q)
			3'd2: acc_q <= {64'd0, pp_q};
			3'd3: acc_q <= acc_q + ({64'd0, pp_q} << 32);
			3'd4: acc_q <= acc_q + ({64'd0, pp_q} << 32);
			3'd5: acc_q <= acc_q + ({64'd0, pp_q} << 64);
			default: acc_q <= acc_q;
		endcase
		if (cnt_q == 3'd6) begin
			prod_q <= neg_q ? -$signed(mag) : $signed(mag);
		end
	end

	assign done = done_q;
	assign prod = prod_q;

endmodule

`default_nettype wire

>>> src/lpe_recip.sv
// Reciprocal unit: -round(2^91 / (1 - x^2)) in Q35, one quotient bit a cycle.
// Uses lpe_pkg.
`default_nettype none

module lpe_recip import lpe_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               go,
	input  logic [27:0]        x_mag,
	output logic               done,
	output logic signed [63:0] recip
);

	localparam int RECIP_STEPS = 91;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_DEN,
		PH_DIV,
		PH_RND
	} phase_t;

	phase_t       phase_q;
	logic [6:0]   cnt_q;
	logic [55:0]  sq_q;
	logic [56:0]  den_q;
	logic [56:0]  rem_q;
	logic [63:0]  quo_q;
	logic         done_q;
	logic signed [63:0] recip_q;
	logic [57:0]  rem2;

	assign rem2 = {rem_q, 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (phase_q)
				PH_IDLE: if (go) begin
					phase_q <= PH_DEN;
				end
				PH_DEN: begin
					cnt_q   <= '0;
					phase_q <= PH_DIV;
				end
				PH_DIV: begin
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q == 7'(RECIP_STEPS - 1)) begin
						phase_q <= PH_RND;
					end
				end
				PH_RND: begin
					done_q  <= 1'b1;
					phase_q <= PH_IDLE;
				end
				default: phase_q <= PH_IDLE;
			endcase
		end
	end

	// Square, denominator, restoring division and final rounding
	always_ff @(posedge clk) begin
		case (phase_q)
			PH_IDLE: sq_q <= 56'(x_mag * x_mag);
			PH_DEN: begin
				den_q <= (57'd1 << 56) - {1'b0, sq_q};
				rem_q <= 57'd1;
				quo_q <= '0;
			end
			PH_DIV: begin
				if (rem2 >= {1'b0, den_q}) begin
					rem_q <= 57'(rem2 - {1'b0, den_q});
					quo_q <= {quo_q[62:0], 1'b1};
				end else begin
					rem_q <= rem2[56:0];
					quo_q <= {quo_q[62:0], 1'b0};
				end
			end
			default: begin
				if (rem2 >= {1'b0, den_q}) begin
					recip_q <= -$signed(quo_q + 64'd1);
				end else begin
					recip_q <= -$signed(quo_q);
				end
			end
		endcase
	end

	assign done  = done_q;
	assign recip = recip_q;

endmodule

`default_nettype wire

>>> src/lpe_datapath.sv
// Datapath: point registers, recurrence state, small divider, scaling and
// result registers. Uses lpe_pkg, lpe_mul and lpe_recip.
`default_nettype none

module lpe_datapath import lpe_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  lpe_cmd_t           cmd,
	output lpe_stat_t          stat,
	input  logic signed [31:0] x_point,
	input  logic [3:0]         deg_in,
	input  logic [1:0]         mode_in,
	output logic               result_valid,
	output logic [3:0]         order_index,
	output logic signed [47:0] poly_value,
	output logic signed [47:0] poly_slope,
	output logic               last_of_run
);

	// Point and run state
	logic signed [31:0] x_q;
	logic               inside_q;
	logic               edge_q;
	logic [3:0]         deg_q;
	logic [1:0]         mode_q;
	logic [3:0]         k_q;
	logic signed [63:0] val_prev_q;
	logic signed [63:0] val_cur_q;
	logic signed [63:0] xp_q;
	logic signed [63:0] slope_q;
	logic signed [63:0] recip_q;
	mul_op_t            mul_op_q;
	logic [47:0]        outv_q;
	logic [47:0]        outs_q;

	// Divider state
	logic [63:0] num_q;
	logic [4:0]  rem_q;
	logic [4:0]  dsr_q;
	logic [2:0]  div_cnt_q;
	logic        div_act_q;
	logic        tneg_q;
	logic        step_done_q;

	// Result registers
	logic        res_valid_q;
	logic [3:0]  res_k_q;
	logic        res_last_q;

	// Unit connections
	logic               mul_done;
	logic signed [63:0] mul_prod;
	logic signed [63:0] mul_a;
	logic signed [63:0] mul_b;
	shift_t             mul_sh;
	logic               recip_done;
	logic signed [63:0] recip_val;

	logic               inside_now;
	logic               edge_now;
	logic [31:0]        x_abs;
	logic signed [63:0] x_ext;
	logic signed [63:0] slope_num;
	logic signed [63:0] scale;
	logic [43:0]        scale_u;
	logic signed [63:0] slope_fixed;
	logic [7:0]         lim_u;
	logic signed [63:0] lim;
	logic signed [63:0] t_c;
	logic [63:0]        t_mag;
	logic [4:0]         k_plus1;
	logic [63:0]        div_n;
	logic [4:0]         div_r;

	function automatic logic [47:0] clamp48(input logic signed [63:0] v);
		if (v > 64'sh0000_7FFF_FFFF_FFFF) begin
			return 48'h7FFF_FFFF_FFFF;
		end else if (v < -64'sh0000_8000_0000_0000) begin
			return 48'h8000_0000_0000;
		end
		return v[47:0];
	endfunction

	// Point classification
	assign inside_now = (x_point >= -ONE_Q28) && (x_point <= ONE_Q28);
	assign edge_now   = (x_point == ONE_Q28) || (x_point == -ONE_Q28);
	assign x_abs      = x_q[31] ? 32'(-x_q) : x_q;
	assign x_ext      = {{32{x_q[31]}}, x_q};

	// Scale factor for degree k
	always_comb begin
		if (deg_q == 4'd0) begin
			scale_u = ONE_Q40[43:0];
		end else begin
			case (mode_q)
				NORM_SQRT_ORDER: scale_u = SQRT_TAB[{k_q, 1'b1}];
				NORM_NONE:       scale_u = ONE_Q40[43:0];
				default:         scale_u = SQRT_TAB[5'd2];
			endcase
		end
		scale = {20'd0, scale_u};
	end

	// Slope without division: low degrees and the edge limit
	assign lim_u = 8'((9'(k_q) * (9'(k_q) + 9'd1)) >> 1);
	assign lim   = {16'd0, lim_u, 40'd0};
	always_comb begin
		if (k_q == 4'd0) begin
			slope_fixed = '0;
		end else if (k_q == 4'd1) begin
			slope_fixed = inside_q ? ONE_Q40 : 64'sd0;
		end else begin
			slope_fixed = (x_q[31] && !k_q[0]) ? -lim : lim;
		end
	end

	// Multiplier operand selection
	assign slope_num = (xp_q - val_prev_q) * $signed({1'b0, k_q});
	always_comb begin
		case (cmd.mul_op)
			MOP_XP: begin
				mul_a  = x_ext;
				mul_b  = val_cur_q;
				mul_sh = SH_28;
			end
			MOP_SLOPE: begin
				mul_a  = slope_num;
				mul_b  = recip_q;
				mul_sh = SH_47;
			end
			MOP_VAL: begin
				mul_a  = val_cur_q;
				mul_b  = scale;
				mul_sh = SH_60;
			end
			default: begin
				mul_a  = slope_q;
				mul_b  = scale;
				mul_sh = SH_48;
			end
		endcase
	end

	// Recurrence numerator and divider setup
	assign t_c     = xp_q * $signed({1'b0, k_q, 1'b1}) - val_prev_q * $signed({1'b0, k_q});
	assign t_mag   = t_c[63] ? 64'(-t_c) : t_c;
	assign k_plus1 = {1'b0, k_q} + 5'd1;

	// Eight quotient bits a cycle, divisor at most 16
	always_comb begin
		logic [5:0] r6;
		div_n = num_q;
		div_r = rem_q;
		for (int i = 0; i < 8; i++) begin
			r6    = {div_r, div_n[63]};
			div_n = {div_n[62:0], 1'b0};
			if (r6 >= {1'b0, dsr_q}) begin
				r6       = r6 - {1'b0, dsr_q};
				div_n[0] = 1'b1;
			end
			div_r = r6[4:0];
		end
	end

	lpe_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (cmd.mul_go),
		.a      (mul_a),
		.b      (mul_b),
		.sh     (mul_sh),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	lpe_recip u_recip (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (cmd.recip_go),
		.x_mag  (x_abs[27:0]),
		.done   (recip_done),
		.recip  (recip_val)
	);

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_act_q   <= 1'b0;
			div_cnt_q   <= '0;
			step_done_q <= 1'b0;
			res_valid_q <= 1'b0;
			k_q         <= '0;
		end else begin
			step_done_q <= 1'b0;
			res_valid_q <= cmd.emit;
			if (cmd.load) begin
				k_q <= '0;
			end else if (cmd.next && k_q == 4'd0) begin
				k_q         <= 4'd1;
				step_done_q <= 1'b1;
			end else if (cmd.next) begin
				div_act_q <= 1'b1;
				div_cnt_q <= '0;
			end else if (div_act_q) begin
				div_cnt_q <= div_cnt_q + 3'd1;
				if (div_cnt_q == 3'd7) begin
					div_act_q   <= 1'b0;
					k_q         <= k_q + 4'd1;
					step_done_q <= 1'b1;
				end
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q        <= x_point;
			inside_q   <= inside_now;
			edge_q     <= edge_now;
			deg_q      <= deg_in;
			mode_q     <= mode_in;
			val_prev_q <= '0;
			val_cur_q  <= inside_now ? ONE_Q52 : 64'sd0;
			recip_q    <= '0;
		end
		if (recip_done) begin
			recip_q <= recip_val;
		end
		if (cmd.mul_go) begin
			mul_op_q <= cmd.mul_op;
		end
		if (mul_done) begin
			case (mul_op_q)
				MOP_XP:    xp_q    <= mul_prod;
				MOP_SLOPE: slope_q <= mul_prod;
				MOP_VAL:   outv_q  <= clamp48(mul_prod);
				default:   outs_q  <= clamp48(mul_prod);
			endcase
		end
		if (cmd.slope_fix) begin
			slope_q <= slope_fixed;
		end
		if (cmd.next && k_q == 4'd0) begin
			val_prev_q <= val_cur_q;
			val_cur_q  <= inside_q ? (x_ext <<< 24) : 64'sd0;
		end else if (cmd.next) begin
			tneg_q <= t_c[63];
			num_q  <= t_mag + 64'(k_plus1 >> 1);
			dsr_q  <= k_plus1;
			rem_q  <= '0;
		end else if (div_act_q) begin
			num_q <= div_n;
			rem_q <= div_r;
			if (div_cnt_q == 3'd7) begin
				val_prev_q <= val_cur_q;
				val_cur_q  <= tneg_q ? -$signed(div_n) : $signed(div_n);
			end
		end
		if (cmd.emit) begin
			res_k_q    <= k_q;
			res_last_q <= (k_q == deg_q);
		end
	end

	// Status to the controller
	assign stat.need_recip   = inside_q && !edge_q && (deg_q >= 4'd2);
	assign stat.recip_done   = recip_done;
	assign stat.mul_done     = mul_done;
	assign stat.k_ge1        = (k_q != 4'd0);
	assign stat.slope_by_mul = (k_q >= 4'd2) && !edge_q;
	assign stat.k_last       = (k_q == deg_q);
	assign stat.step_done    = step_done_q;

	assign result_valid = res_valid_q;
	assign order_index  = res_k_q;
	assign poly_value   = outv_q;
	assign poly_slope   = outs_q;
	assign last_of_run  = res_last_q;

endmodule

`default_nettype wire

>>> src/lpe_ctrl.sv
// Controller state machine: sequences load, reciprocal, per-degree products,
// result strobe and recurrence step. Uses lpe_pkg.
`default_nettype none

module lpe_ctrl import lpe_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	output lpe_cmd_t  cmd,
	input  lpe_stat_t stat
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD,
		ST_CHECK,
		ST_RECIP,
		ST_TOP,
		ST_XP_W,
		ST_SLOPE,
		ST_SLP_W,
		ST_SCV_W,
		ST_SCS_W,
		ST_EMIT,
		ST_NEXT_W
	} state_t;

	state_t   state_q;
	logic     busy_q;
	lpe_cmd_t cmd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy_q  <= 1'b0;
			cmd_q   <= '0;
		end else begin
			cmd_q <= '0;
			case (state_q)
				ST_IDLE: if (start) begin
					cmd_q.load <= 1'b1;
					busy_q     <= 1'b1;
					state_q    <= ST_LOAD;
				end
				ST_LOAD: state_q <= ST_CHECK;
				ST_CHECK: begin
					if (stat.need_recip) begin
						cmd_q.recip_go <= 1'b1;
						state_q        <= ST_RECIP;
					end else begin
						state_q <= ST_TOP;
					end
				end
				ST_RECIP: if (stat.recip_done) begin
					state_q <= ST_TOP;
				end
				// x * P_k, shared by slope and recurrence
				ST_TOP: begin
					if (stat.k_ge1) begin
						cmd_q.mul_go <= 1'b1;
						cmd_q.mul_op <= MOP_XP;
						state_q      <= ST_XP_W;
					end else begin
						state_q <= ST_SLOPE;
					end
				end
				ST_XP_W: if (stat.mul_done) begin
					state_q <= ST_SLOPE;
				end
				ST_SLOPE: begin
					cmd_q.mul_go <= 1'b1;
					if (stat.slope_by_mul) begin
						cmd_q.mul_op <= MOP_SLOPE;
						state_q      <= ST_SLP_W;
					end else begin
						cmd_q.slope_fix <= 1'b1;
						cmd_q.mul_op    <= MOP_VAL;
						state_q         <= ST_SCV_W;
					end
				end
				ST_SLP_W: if (stat.mul_done) begin
					cmd_q.mul_go <= 1'b1;
					cmd_q.mul_op <= MOP_VAL;
					state_q      <= ST_SCV_W;
				end
				ST_SCV_W: if (stat.mul_done) begin
					cmd_q.mul_go <= 1'b1;
					cmd_q.mul_op <= MOP_SLP;
					state_q      <= ST_SCS_W;
				end
				ST_SCS_W: if (stat.mul_done) begin
					cmd_q.emit <= 1'b1;
					state_q    <= ST_EMIT;
				end
				ST_EMIT: begin
					if (stat.k_last) begin
						busy_q  <= 1'b0;
						state_q <= ST_IDLE;
					end else begin
						cmd_q.next <= 1'b1;
						state_q    <= ST_NEXT_W;
					end
				end
				ST_NEXT_W: if (stat.step_done) begin
					state_q <= ST_TOP;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy = busy_q;
	assign cmd  = cmd_q;

endmodule

`default_nettype wire

>>> dv/testbench.sv
// Self-checking testbench for legendre_poly_eval: directed and random points
// under several degree/normalization settings, checked against a bit-exact predictor.
// Depends on lpe_pkg and the legendre_poly_eval RTL.
`timescale 1ns / 100ps

module testbench;
	import lpe_pkg::*;

	localparam int MAX_DEG = 15;
	// Indexes past the two registers; writes there must be ignored
	localparam logic [1:0] CFG_SPARE_A = 2'd2;
	localparam logic [1:0] CFG_SPARE_B = 2'd3;
	localparam logic signed [31:0] X_ONE = 32'sd268435456;

	typedef struct {
		logic [3:0]  k;
		logic [47:0] value;
		logic [47:0] slope;
		logic        last;
	} term_t;

	// Predicts the Legendre terms for each accepted point and checks the outputs
	class legendre_predictor;
		logic [3:0] degree;
		logic [1:0] mode;
		term_t      pending_terms[$];
		int         failures;
		int         mismatches;

		function new();
			degree     = '0;
			mode       = NORM_SQRT_ORDER;
			failures   = 0;
			mismatches = 0;
		endfunction

		function void write_reg(logic [1:0] index, logic [3:0] data);
			if (index == CFG_POLY_DEGREE)
				degree = data;
			else if (index == CFG_NORM_MODE)
				mode = data[1:0];
		endfunction

		// (a*b) >> sh, rounded half away from zero, saturated to 64 bits
		function longint round_mul(longint a, longint b, int sh);
			logic [63:0]  ua;
			logic [63:0]  ub;
			logic [127:0] prod;
			logic         neg;
			neg  = (a < 0) != (b < 0);
			ua   = (a < 0) ? -a : a;
			ub   = (b < 0) ? -b : b;
			prod = {64'd0, ua} * {64'd0, ub};
			prod = (prod + (128'd1 << (sh - 1))) >> sh;
			if (prod > 128'h7FFF_FFFF_FFFF_FFFF)
				prod = 128'h7FFF_FFFF_FFFF_FFFF;
			return neg ? -longint'(prod[63:0]) : longint'(prod[63:0]);
		endfunction

		// floor(sqrt(n) * 2^40) by bitwise search
		function longint root_q40(int n);
			logic [127:0] target;
			logic [127:0] r;
			logic [127:0] t;
			target = 128'(n) << 80;
			r = '0;
			for (int b = 43; b >= 0; b--) begin
				t = r | (128'd1 << b);
				if (t * t <= target)
					r = t;
			end
			return longint'(r[63:0]);
		endfunction

		function logic [47:0] sat48(longint v);
			if (v > 64'sh7FFF_FFFF_FFFF)
				return 48'h7FFF_FFFF_FFFF;
			if (v < -64'sh8000_0000_0000)
				return 48'h8000_0000_0000;
			return v[47:0];
		endfunction

		function void note_point(logic signed [31:0] xin);
			longint       val[16];
			longint       slp[16];
			longint       x;
			longint       t;
			longint       recip;
			longint       scale;
			longint       lim;
			logic [63:0]  mag;
			logic [127:0] den;
			logic [127:0] q;
			logic         in_range;
			logic         at_edge;
			int           d;
			term_t        e;
			x = xin;
			d = (degree > MAX_DEG) ? MAX_DEG : degree;
			in_range = x >= -longint'(X_ONE) && x <= longint'(X_ONE);
			at_edge  = x == longint'(X_ONE) || x == -longint'(X_ONE);
			for (int k = 0; k < 16; k++) begin
				val[k] = 0;
				slp[k] = 0;
			end
			if (in_range) begin
				val[0] = 64'sd1 <<< 52;
				if (d >= 1) begin
					val[1] = x * (64'sd1 <<< 24);
					slp[1] = 64'sd1 <<< 40;
				end
				// three-term recurrence in Q52
				for (int k = 1; k < d; k++) begin
					t   = longint'(2 * k + 1) * round_mul(x, val[k], 28) - longint'(k) * val[k - 1];
					mag = (t < 0) ? -t : t;
					mag = (mag + 64'((k + 1) / 2)) / 64'(k + 1);
					val[k + 1] = (t < 0) ? -longint'(mag) : longint'(mag);
				end
				recip = 0;
				if (!at_edge && d >= 2) begin
					den   = 128'((64'sd1 <<< 56) - x * x);
					q     = ((128'd1 << 92) + den) / (den << 1);
					recip = -longint'(q[63:0]);
				end
				// slopes; closed-form limit at the interval ends
				for (int k = 2; k <= d; k++) begin
					if (at_edge) begin
						lim    = longint'(k * (k + 1) / 2) * (64'sd1 <<< 40);
						slp[k] = (x < 0 && k % 2 == 0) ? -lim : lim;
					end else begin
						t      = longint'(k) * (round_mul(x, val[k], 28) - val[k - 1]);
						slp[k] = round_mul(t, recip, 47);
					end
				end
			end
			for (int k = 0; k <= d; k++) begin
				scale = 64'sd1 <<< 40;
				if (d > 0) begin
					if (mode == NORM_SQRT_ORDER)
						scale = root_q40(2 * k + 1);
					else if (mode != NORM_NONE)
						scale = root_q40(2);
				end
				e.k     = 4'(k);
				e.value = sat48(round_mul(val[k], scale, 60));
				e.slope = sat48(round_mul(slp[k], scale, 48));
				e.last  = (k == d);
				pending_terms.push_back(e);
			end
		endfunction

		function void check_term(logic [3:0] k, logic [47:0] v, logic [47:0] s, logic last);
			term_t e;
			if (pending_terms.size() == 0) begin
				failures++;
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result k=%0d value=%h slope=%h", k, v, s);
				return;
			end
			e = pending_terms.pop_front();
			if (e.k !== k || e.value !== v || e.slope !== s || e.last !== last) begin
				failures++;
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: exp k=%0d v=%h s=%h last=%b, got k=%0d v=%h s=%h last=%b",
						e.k, e.value, e.slope, e.last, k, v, s, last);
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic signed [31:0] x_point;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [1:0]         cfg_index;
	logic [3:0]         cfg_data;
	logic               result_valid;
	logic [3:0]         order_index;
	logic signed [47:0] poly_value;
	logic signed [47:0] poly_slope;
	logic               last_of_run;

	legendre_predictor pred = new();

	legendre_poly_eval #(.MAX_DEGREE(MAX_DEG)) dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .x_point(x_point),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .result_valid(result_valid), .order_index(order_index),
		.poly_value(poly_value), .poly_slope(poly_slope), .last_of_run(last_of_run)
	);

	// clock
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && result_valid)
			pred.check_term(order_index, poly_value, poly_slope, last_of_run);
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// one point transaction; start stays high across back-to-back points
	task automatic send_point(logic signed [31:0] x);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start   <= 1'b1;
		x_point <= x;
		do @(posedge clk); while (busy);
		pred.note_point(x);
	endtask

	task automatic wait_idle();
		start <= 1'b0;
		while (pred.pending_terms.size() != 0)
			@(posedge clk);
		@(posedge clk);
		while (busy)
			@(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	task automatic write_cfg(logic [1:0] index, logic [3:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		pred.write_reg(index, data);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic signed [31:0] rand_point();
		int r;
		r = $urandom_range(0, 99);
		if (r < 75)
			return 32'($urandom_range(0, 32'h2000_0000)) - X_ONE;
		if (r < 85)
			return $urandom();
		if (r < 90)
			return $urandom_range(0, 1) ? X_ONE : -X_ONE;
		if (r < 95)
			return $urandom_range(0, 1) ? X_ONE - 32'sd1 : -X_ONE + 32'sd1;
		return $urandom_range(0, 1) ? X_ONE + 32'sd1 : -X_ONE - 32'sd1;
	endfunction

	logic signed [31:0] corner_pts[12] = '{
		32'sd0, X_ONE, -X_ONE, X_ONE + 32'sd1, -X_ONE - 32'sd1,
		32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd1, -32'sd1,
		X_ONE - 32'sd1, -X_ONE + 32'sd1, 32'sh0800_0000
	};

	initial begin
		arst_n    = 1'b0;
		start     = 1'b0;
		x_point   = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_POLY_DEGREE;
		cfg_data  = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// directed: reset settings (degree 0), full degree with modes 0 and 3, then degrees 1 and 2 with the other modes
		send_point(32'sh0400_0000);
		send_point(-X_ONE);
		wait_idle();
		write_cfg(CFG_POLY_DEGREE, 4'd15);
		write_cfg(CFG_NORM_MODE, 4'd0);
		foreach (corner_pts[i])
			send_point(corner_pts[i]);
		wait_idle();
		write_cfg(CFG_NORM_MODE, 4'hF);   // masks to 3, acts like sqrt(2) scaling
		write_cfg(CFG_SPARE_A, 4'd0);
		write_cfg(CFG_SPARE_B, 4'd5);
		send_point(32'sh0C00_0000);
		send_point(X_ONE);
		wait_idle();
		write_cfg(CFG_NORM_MODE, 4'(NORM_NONE));
		write_cfg(CFG_POLY_DEGREE, 4'd1);
		send_point(-32'sh0C00_0000);
		send_point(32'sh1234_5678);
		wait_idle();
		write_cfg(CFG_NORM_MODE, 4'(NORM_SQRT_TWO));
		write_cfg(CFG_POLY_DEGREE, 4'd2);
		send_point(-X_ONE);
		send_point(32'sh0000_1000);
		wait_idle();

		// random phases, each with its own setting
		for (int ph = 0; ph < 8; ph++) begin
			write_cfg(CFG_POLY_DEGREE, (ph == 0) ? 4'd15 : (ph == 1) ? 4'd0 : 4'($urandom()));
			write_cfg(CFG_NORM_MODE, 4'($urandom()));
			for (int i = 0; i < 58; i++)
				send_point(rand_point());
			wait_idle();
		end

		if (pred.failures == 0 && pred.pending_terms.size() == 0)
			$display("PASS legendre_poly_eval");
		else
			$display("FAIL legendre_poly_eval");
		$finish;
	end

	// watchdog
	initial begin
		#30_000_000;
		$display("FAIL legendre_poly_eval");
		$finish;
	end

endmodule
